// ===== rtl/core/pladc_pkg.sv =====
// ============================================================================
// pladc_pkg
// Shared constants and calibration tables for the ADC-to-distance converter.
// ============================================================================
package pladc_pkg;

    // Sample and result widths.
    localparam int SAMPLE_BITS = 12;
    localparam int MM_BITS     = 8;

    // Calibration points and the segments between them.
    localparam int NUM_POINTS  = 24;
    localparam int SEG_COUNT   = NUM_POINTS - 1;
    localparam int SEG_BITS    = $clog2(SEG_COUNT);

    // Arithmetic widths: the widest segment spans 803 codes, the steepest
    // distance step is 10 mm, so the rounded numerator stays below 2^14.
    localparam int DIFF_BITS   = 10;
    localparam int DD_BITS     = 4;
    localparam int NUM_BITS    = 14;
    localparam int Q_BITS      = 4;

    // Reciprocal scaling: floor(n / d) equals (n * ceil(2^24 / d)) >> 24 for
    // every numerator below 2^14 and every divisor below 2^10.
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_BITS  = 20;
    localparam int PROD_BITS   = NUM_BITS + RECIP_BITS;

    // Raw converter codes of the calibration points, falling with distance.
    localparam logic [SAMPLE_BITS-1:0] ROM_RAW [NUM_POINTS] = '{
        12'd3550, 12'd2747, 12'd2549, 12'd2227, 12'd2060, 12'd1891,
        12'd1796, 12'd1678, 12'd1552, 12'd1450, 12'd1377, 12'd1248,
        12'd1175, 12'd1127, 12'd1074, 12'd1019, 12'd976,  12'd910,
        12'd887,  12'd845,  12'd804,  12'd764,  12'd745,  12'd716
    };

    // Distances of the calibration points in millimetres.
    localparam logic [MM_BITS-1:0] ROM_MM [NUM_POINTS] = '{
        8'd40,  8'd50,  8'd55,  8'd60,  8'd65,  8'd70,  8'd75,  8'd80,
        8'd85,  8'd90,  8'd95,  8'd100, 8'd105, 8'd110, 8'd115, 8'd120,
        8'd125, 8'd130, 8'd135, 8'd140, 8'd145, 8'd150, 8'd155, 8'd160
    };

    // Scaled reciprocal ceil(2^24 / den) of each segment's code span.
    localparam logic [RECIP_BITS-1:0] SEG_RECIP [SEG_COUNT] = '{
        20'd20894,  20'd84734,  20'd52104,  20'd100463, 20'd99274,
        20'd176603, 20'd142180, 20'd133153, 20'd164483, 20'd229825,
        20'd130056, 20'd229825, 20'd349526, 20'd316552, 20'd305041,
        20'd390168, 20'd254201, 20'd729445, 20'd399458, 20'd409201,
        20'd419431, 20'd883012, 20'd578525
    };

    typedef logic [SEG_BITS-1:0] t_seg;

    // Code span of one segment.
    function automatic logic [DIFF_BITS-1:0] seg_den(input t_seg seg);
        logic [SAMPLE_BITS-1:0] span;
        span = ROM_RAW[seg] - ROM_RAW[seg + 1'b1];
        return span[DIFF_BITS-1:0];
    endfunction

    // Distance step of one segment.
    function automatic logic [DD_BITS-1:0] seg_dd(input t_seg seg);
        logic [MM_BITS-1:0] step;
        step = ROM_MM[seg + 1'b1] - ROM_MM[seg];
        return step[DD_BITS-1:0];
    endfunction

endpackage

// ===== rtl/core/piecewise_linear_adc_to_distance_top.sv =====
// ============================================================================
// piecewise_linear_adc_to_distance_top
// Converts raw distance-sensor samples to millimetres by piecewise-linear
// interpolation over a 24-point calibration table.
// ============================================================================
//
// Usage:
//   Input channel: drive i_adc_sample and raise start; the sample transfers at
//   the clock edge where start is high and busy is low. busy is low whenever
//   the block is out of reset, so one sample may transfer every cycle.
//   Output channel: o_valid is high for exactly one cycle with the distance on
//   o_dist_mm; the receiver must take it in that cycle.
//   The captured sample passes the segment, numerator, quotient and output
//   registers in turn. Throughput: one sample per cycle, set by the five-stage
//   pipeline (segment search, numerator, reciprocal multiply, offset add,
//   output register), every stage of which accepts a new item each cycle.
//   Samples at or above code 3550 give 40 mm; at or below code 716, 160 mm.
//   Results are rounded half up to the nearest millimetre.
//   Reset: synchronous and active low; it empties the pipeline, drops any
//   samples in flight and holds busy high while asserted.
//   There is no backpressure: the receiver cannot stall the block.
//
module piecewise_linear_adc_to_distance_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [pladc_pkg::SAMPLE_BITS-1:0]    i_adc_sample,
    output logic                                 o_valid,
    output logic [pladc_pkg::MM_BITS-1:0]        o_dist_mm
);

    // Stage 1 registers: captured sample.
    logic                                   r_s1_valid;
    logic [pladc_pkg::SAMPLE_BITS-1:0]      r_s1_sample;

    // Stage 2 registers: segment and clamp flags.
    logic                                   r_s2_valid;
    logic [pladc_pkg::SAMPLE_BITS-1:0]      r_s2_sample;
    pladc_pkg::t_seg                        r_s2_seg;
    logic                                   r_s2_near;
    logic                                   r_s2_far;
    pladc_pkg::t_seg                        n_s2_seg;
    logic                                   n_s2_near;
    logic                                   n_s2_far;

    // Stage 3 registers: rounded numerator.
    logic                                   r_s3_valid;
    pladc_pkg::t_seg                        r_s3_seg;
    logic [pladc_pkg::NUM_BITS-1:0]         r_s3_num;
    logic [pladc_pkg::NUM_BITS-1:0]         n_s3_num;

    // Stage 4 registers: interpolation quotient.
    logic                                   r_s4_valid;
    pladc_pkg::t_seg                        r_s4_seg;
    logic [pladc_pkg::Q_BITS-1:0]           r_s4_quot;
    logic [pladc_pkg::Q_BITS-1:0]           n_s4_quot;

    // Stage 5 registers: output.
    logic                                   r_s5_valid;
    logic [pladc_pkg::MM_BITS-1:0]          r_s5_dist;
    logic [pladc_pkg::MM_BITS-1:0]          n_s5_dist;

    // The block only refuses samples while reset is held.
    assign busy = ~i_rst_n;

    // Valid bits travel with the data through every stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_s5_valid <= 1'b0;
        end else begin
            r_s1_valid <= start & ~busy;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
            r_s5_valid <= r_s4_valid;
        end
    end

    // Segment search: count the points above the sample, with both clamps.
    always_comb begin
        logic [pladc_pkg::SEG_BITS-1:0] count;
        count = '0;
        for (int j = 1; j < pladc_pkg::NUM_POINTS; j++) begin
            if (pladc_pkg::ROM_RAW[j] > r_s1_sample) begin
                count = count + 1'b1;
            end
        end
        n_s2_near = (r_s1_sample >= pladc_pkg::ROM_RAW[0]);
        n_s2_far  = (r_s1_sample <= pladc_pkg::ROM_RAW[pladc_pkg::NUM_POINTS-1]);
        if (n_s2_near) begin
            n_s2_seg = '0;
        end else if (n_s2_far) begin
            n_s2_seg = pladc_pkg::SEG_BITS'(pladc_pkg::SEG_COUNT - 1);
        end else begin
            n_s2_seg = count;
        end
    end

    // Numerator: distance step times offset into the segment, plus half span.
    // The near clamp uses a zero offset and the far clamp the full span, so
    // both fall out of the same arithmetic as the segment end points.
    always_comb begin
        logic [pladc_pkg::SAMPLE_BITS-1:0] raw_diff;
        logic [pladc_pkg::DIFF_BITS-1:0]   diff;
        logic [pladc_pkg::DIFF_BITS-1:0]   den;
        den      = pladc_pkg::seg_den(r_s2_seg);
        raw_diff = pladc_pkg::ROM_RAW[r_s2_seg] - r_s2_sample;
        if (r_s2_near) begin
            diff = '0;
        end else if (r_s2_far) begin
            diff = den;
        end else begin
            diff = raw_diff[pladc_pkg::DIFF_BITS-1:0];
        end
        n_s3_num = pladc_pkg::NUM_BITS'(
                       pladc_pkg::NUM_BITS'(pladc_pkg::seg_dd(r_s2_seg))
                       * pladc_pkg::NUM_BITS'(diff))
                   + pladc_pkg::NUM_BITS'(den >> 1);
    end

    // Division by the segment span through its scaled reciprocal.
    always_comb begin
        logic [pladc_pkg::PROD_BITS-1:0] prod;
        prod = pladc_pkg::PROD_BITS'(r_s3_num)
               * pladc_pkg::PROD_BITS'(pladc_pkg::SEG_RECIP[r_s3_seg]);
        n_s4_quot = prod[pladc_pkg::RECIP_SHIFT +: pladc_pkg::Q_BITS];
    end

    // Add the interpolated step to the segment's starting distance.
    assign n_s5_dist = pladc_pkg::ROM_MM[r_s4_seg] + pladc_pkg::MM_BITS'(r_s4_quot);

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_s1_sample <= i_adc_sample;
        r_s2_sample <= r_s1_sample;
        r_s2_seg    <= n_s2_seg;
        r_s2_near   <= n_s2_near;
        r_s2_far    <= n_s2_far;
        r_s3_seg    <= r_s2_seg;
        r_s3_num    <= n_s3_num;
        r_s4_seg    <= r_s3_seg;
        r_s4_quot   <= n_s4_quot;
        r_s5_dist   <= n_s5_dist;
    end

    assign o_valid   = r_s5_valid;
    assign o_dist_mm = r_s5_dist;

`ifndef NO_ASSERTIONS
    // Every transfer in gives exactly one result strobe on o_valid.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid == $past(start && !busy, 5))
        else $error("result strobe does not match accepted samples");

    // The quotient never exceeds the segment's distance step.
    a_quot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s4_valid |-> (r_s4_quot <= pladc_pkg::seg_dd(r_s4_seg)))
        else $error("interpolation quotient beyond segment step");

    // Results stay within the calibrated distance range.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_dist_mm >= pladc_pkg::ROM_MM[0]
                     && o_dist_mm <= pladc_pkg::ROM_MM[pladc_pkg::NUM_POINTS-1]))
        else $error("distance outside calibrated range");
`endif

endmodule

// ===== tb/piecewise_linear_adc_to_distance_top_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// piecewise_linear_adc_to_distance_top_tb
// Self-checking bench for the ADC-to-distance converter. A queue of samples
// (directed end points, calibration points and rounding cases, then random
// codes weighted towards the interpolated range) feeds a falling-edge driver
// with varying idle phases. A rising-edge monitor predicts each distance from
// its own copy of the calibration table and compares it with every result.
// ============================================================================
module piecewise_linear_adc_to_distance_top_tb;

    localparam int CAL_POINTS    = 24;
    localparam int RANDOM_ITEMS  = 628;
    localparam int STALL_LIMIT   = 2000;
    localparam int FLUSH_CYCLES  = 10;
    localparam int PHASE_LENGTH  = 80;

    // Calibration table: converter codes fall as the distance rises.
    localparam int CAL_CODE [CAL_POINTS] = '{
        3550, 2747, 2549, 2227, 2060, 1891, 1796, 1678,
        1552, 1450, 1377, 1248, 1175, 1127, 1074, 1019,
         976,  910,  887,  845,  804,  764,  745,  716
    };
    localparam int CAL_MM [CAL_POINTS] = '{
         40,  50,  55,  60,  65,  70,  75,  80,
         85,  90,  95, 100, 105, 110, 115, 120,
        125, 130, 135, 140, 145, 150, 155, 160
    };

    // Sender idle percentage of each phase, repeated in turn.
    localparam int IDLE_PCT [4] = '{0, 87, 0, 15};

    typedef struct {
        logic [pladc_pkg::SAMPLE_BITS-1:0] code;
        bit                                drain_first;
    } t_adc_req;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              start = 1'b0;
    logic                              busy;
    logic [pladc_pkg::SAMPLE_BITS-1:0] i_adc_sample = '0;
    logic                              o_valid;
    logic [pladc_pkg::MM_BITS-1:0]     o_dist_mm;

    t_adc_req                      sample_queue [$];
    logic [pladc_pkg::MM_BITS-1:0] distance_expected [$];
    logic                          sample_taken = 1'b0;
    int unsigned                   sent_count = 0;
    int unsigned                   error_count = 0;
    int unsigned                   quiet_cycles = 0;

    piecewise_linear_adc_to_distance_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_adc_sample  (i_adc_sample),
        .o_valid       (o_valid),
        .o_dist_mm     (o_dist_mm)
    );

    // 100 MHz clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Distance of a sample: clamp at the table ends, otherwise interpolate
    // in the first segment that holds it, rounding half up.
    function automatic logic [pladc_pkg::MM_BITS-1:0] pl_distance(
        input logic [pladc_pkg::SAMPLE_BITS-1:0] code);
        int x;
        int k;
        int span;
        int step;
        int numer;
        x = code;
        if (x >= CAL_CODE[0]) return pladc_pkg::MM_BITS'(CAL_MM[0]);
        if (x <= CAL_CODE[CAL_POINTS-1]) return pladc_pkg::MM_BITS'(CAL_MM[CAL_POINTS-1]);
        for (k = 0; k < CAL_POINTS - 1; k++) begin
            if (x <= CAL_CODE[k] && x >= CAL_CODE[k+1]) begin
                span = CAL_CODE[k] - CAL_CODE[k+1];
                step = CAL_MM[k+1] - CAL_MM[k];
                if (span == 0) return pladc_pkg::MM_BITS'(CAL_MM[k]);
                numer = step * (CAL_CODE[k] - x) + span / 2;
                return pladc_pkg::MM_BITS'(CAL_MM[k] + numer / span);
            end
        end
        return pladc_pkg::MM_BITS'(CAL_MM[CAL_POINTS-1]);
    endfunction

    // Random code: mostly inside the interpolated range, some anywhere, and
    // some within a few codes of a calibration point.
    function automatic logic [pladc_pkg::SAMPLE_BITS-1:0] random_code();
        int pick;
        int pt;
        pick = $urandom_range(99);
        if (pick < 35) return pladc_pkg::SAMPLE_BITS'($urandom);
        if (pick < 80) begin
            return pladc_pkg::SAMPLE_BITS'(
                $urandom_range(CAL_CODE[0], CAL_CODE[CAL_POINTS-1]));
        end
        pt = $urandom_range(CAL_POINTS - 1);
        return pladc_pkg::SAMPLE_BITS'(CAL_CODE[pt] + int'($urandom_range(4)) - 2);
    endfunction

    task automatic queue_sample(input int code, input bit drain_first);
        t_adc_req req;
        req.code        = pladc_pkg::SAMPLE_BITS'(code);
        req.drain_first = drain_first;
        sample_queue.push_back(req);
    endtask

    // Driver: offers the next sample once the previous one has transferred.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || sample_taken) begin
            if (sample_queue.size() == 0) begin
                start <= 1'b0;
            end else if (sample_queue[0].drain_first && distance_expected.size() != 0) begin
                // Hold off until every result in flight has come back.
                start <= 1'b0;
            end else if ($urandom_range(99) < IDLE_PCT[(sent_count / PHASE_LENGTH) % 4]) begin
                start        <= 1'b0;
                i_adc_sample <= pladc_pkg::SAMPLE_BITS'($urandom);
            end else begin
                start        <= 1'b1;
                i_adc_sample <= sample_queue[0].code;
                sample_queue.pop_front();
                sent_count++;
            end
        end
    end

    // Monitor: checks results, records input transfers and watches for a hang.
    always @(posedge i_clk) begin
        if (o_valid) begin
            if (distance_expected.size() == 0) begin
                $error("dist_mm: unexpected result %0d", o_dist_mm);
                error_count++;
            end else begin
                if (o_dist_mm !== distance_expected[0]) begin
                    $error("dist_mm: expected %0d, actual %0d",
                           distance_expected[0], o_dist_mm);
                    error_count++;
                end
                distance_expected.pop_front();
            end
        end

        sample_taken <= start && !busy;
        if (start && !busy) begin
            distance_expected.push_back(pl_distance(i_adc_sample));
        end

        if ((start && !busy) || o_valid) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("** piecewise_linear_adc_to_distance_top: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        // Directed: field extremes, both clamps and their edges, alternating
        // bit patterns, calibration points and codes just inside segments.
        queue_sample(0, 1'b0);
        queue_sample(4095, 1'b0);
        queue_sample(12'hAAA, 1'b0);
        queue_sample(12'h555, 1'b0);
        queue_sample(3551, 1'b0);
        queue_sample(3550, 1'b0);
        queue_sample(3549, 1'b0);
        queue_sample(717, 1'b0);
        queue_sample(716, 1'b0);
        queue_sample(715, 1'b0);
        queue_sample(2747, 1'b0);
        queue_sample(2748, 1'b0);
        queue_sample(2746, 1'b0);
        queue_sample(1450, 1'b1);
        queue_sample(1019, 1'b0);
        queue_sample(887, 1'b0);
        queue_sample(745, 1'b0);
        queue_sample(3148, 1'b0);   // near the midpoint of the widest segment
        queue_sample(3149, 1'b0);
        queue_sample(2148, 1'b0);
        queue_sample(730, 1'b0);
        queue_sample(2048, 1'b0);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            queue_sample(random_code(), (n == RANDOM_ITEMS / 2));
        end

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (sample_queue.size() != 0 || start || distance_expected.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (FLUSH_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("** piecewise_linear_adc_to_distance_top: PASSED **");
        end else begin
            $display("** piecewise_linear_adc_to_distance_top: FAILED **");
        end
        $finish;
    end

endmodule
